// ----- rtl/llsf_pkg.sv -----
package llsf_pkg;

	// Operand, product and quotient widths of the shared arithmetic units
	localparam int OPW    = 64;
	localparam int WW     = 128;
	localparam int NUMW   = 160;
	localparam int ITER_W = 8;
	localparam int STEP_W = 4;

	localparam logic [ITER_W-1:0] MUL_LAST  = ITER_W'(OPW - 1);
	localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(NUMW - 1);
	localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(OPW / 2 - 1);

	// after this program step the centered sums are known and the degenerate cases decided
	localparam logic [STEP_W-1:0] CHECK_STEP = STEP_W'(5);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_FLAT = 2'd2,
		ST_SAT  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		SRC_N, SRC_N2, SRC_SX, SRC_SY, SRC_SXX, SRC_SXY, SRC_SYY, SRC_D, SRC_NXY, SRC_NYY
	} src_t;

	typedef enum logic [2:0] {
		DST_D, DST_NXY, DST_NYY, DST_P, DST_E, DST_K
	} dst_t;

	typedef enum logic [1:0] {
		DV_SLOPE, DV_ICPT, DV_T, DV_V
	} div_sel_t;

	typedef enum logic [1:0] {
		K_MUL, K_DIV, K_SQRT
	} kind_t;

	typedef struct packed {
		kind_t    kind;
		src_t     src_a;
		src_t     src_b;
		dst_t     dst;
		logic     sub;
		div_sel_t div_sel;
	} step_t;

	typedef struct packed {
		logic     acc_en;
		logic     mul_load;
		logic     mul_step;
		logic     mul_commit;
		logic     div_load;
		logic     div_step;
		logic     div_store;
		logic     sqrt_load;
		logic     sqrt_step;
		logic     res_load;
		src_t     src_a;
		src_t     src_b;
		dst_t     dst;
		logic     sub;
		div_sel_t div_sel;
	} cmd_t;

	typedef struct packed {
		logic few_points;
		logic zero_spread;
	} stat_t;

	function automatic step_t mk_step(input kind_t k, input src_t a, input src_t b,
			input dst_t d, input logic s, input div_sel_t v);
		step_t r;
		r.kind    = k;
		r.src_a   = a;
		r.src_b   = b;
		r.dst     = d;
		r.sub     = s;
		r.div_sel = v;
		return r;
	endfunction

	// Fit program: products accumulate into the centered sums and intermediates, then four divisions and a root
	function automatic step_t program_step(input logic [STEP_W-1:0] idx);
		step_t s;
		unique case (idx)
			4'd0:  s = mk_step(K_MUL,  SRC_N,   SRC_SXX, DST_D,   1'b0, DV_SLOPE);
			4'd1:  s = mk_step(K_MUL,  SRC_SX,  SRC_SX,  DST_D,   1'b1, DV_SLOPE);
			4'd2:  s = mk_step(K_MUL,  SRC_N,   SRC_SXY, DST_NXY, 1'b0, DV_SLOPE);
			4'd3:  s = mk_step(K_MUL,  SRC_SX,  SRC_SY,  DST_NXY, 1'b1, DV_SLOPE);
			4'd4:  s = mk_step(K_MUL,  SRC_N,   SRC_SYY, DST_NYY, 1'b0, DV_SLOPE);
			4'd5:  s = mk_step(K_MUL,  SRC_SY,  SRC_SY,  DST_NYY, 1'b1, DV_SLOPE);
			4'd6:  s = mk_step(K_MUL,  SRC_SY,  SRC_SXX, DST_P,   1'b0, DV_SLOPE);
			4'd7:  s = mk_step(K_MUL,  SRC_SX,  SRC_SXY, DST_P,   1'b1, DV_SLOPE);
			4'd8:  s = mk_step(K_MUL,  SRC_NYY, SRC_D,   DST_E,   1'b0, DV_SLOPE);
			4'd9:  s = mk_step(K_MUL,  SRC_NXY, SRC_NXY, DST_E,   1'b1, DV_SLOPE);
			4'd10: s = mk_step(K_MUL,  SRC_D,   SRC_N2,  DST_K,   1'b0, DV_SLOPE);
			4'd11: s = mk_step(K_DIV,  SRC_N,   SRC_N,   DST_D,   1'b0, DV_SLOPE);
			4'd12: s = mk_step(K_DIV,  SRC_N,   SRC_N,   DST_D,   1'b0, DV_ICPT);
			4'd13: s = mk_step(K_DIV,  SRC_N,   SRC_N,   DST_D,   1'b0, DV_T);
			4'd14: s = mk_step(K_DIV,  SRC_N,   SRC_N,   DST_D,   1'b0, DV_V);
			4'd15: s = mk_step(K_SQRT, SRC_N,   SRC_N,   DST_D,   1'b0, DV_SLOPE);
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/llsf_in_if.sv -----
interface llsf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_value;
	logic signed [15:0] y_value;
	logic               last_sample;

	modport source(output valid, output x_value, output y_value, output last_sample,
		input ready);
	modport sink(input valid, input x_value, input y_value, input last_sample,
		output ready);
endinterface

// ----- rtl/llsf_out_if.sv -----
interface llsf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] slope_out;
	logic signed [31:0] intercept_out;
	logic        [31:0] slope_error_out;
	logic        [1:0]  fit_status;

	modport source(output valid, output slope_out, output intercept_out,
		output slope_error_out, output fit_status, input ready);
	modport sink(input valid, input slope_out, input intercept_out,
		input slope_error_out, input fit_status, output ready);
endinterface

// ----- rtl/linear_least_squares_fit.sv -----
// Least-squares line fit over a set of (x, y) pairs in signed Q7.8. One pair is taken
// every cycle while accumulating; a pair with last_sample set is accumulated and then
// the block computes slope, intercept (both Q15.16) and the slope's standard error
// (unsigned Q16.16), saturated, with fit_status flagging too few points, no x spread
// or saturation. The fit runs on one 64x64 shift-add multiplier (11 products), one
// 160-bit restoring divider (4 divisions) and a bitwise square root; when the set has
// fewer than three points or no x spread, the fit stops after the centered sums and
// skips the remaining products, the divisions and the root. Samples are not taken
// while the fit runs. A finished result waits in the output register while the next
// set accumulates. Pairs past MAX_POINTS in one set are dropped from the sums.
module linear_least_squares_fit #(
	parameter int MAX_POINTS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	llsf_in_if.sink           samples,
	llsf_out_if.source        results
);

	llsf_pkg::cmd_t  cmd;
	llsf_pkg::stat_t stat;

	llsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (samples.last_sample),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	llsf_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.x_value         (samples.x_value),
		.y_value         (samples.y_value),
		.slope_out       (results.slope_out),
		.intercept_out   (results.intercept_out),
		.slope_error_out (results.slope_error_out),
		.fit_status      (results.fit_status)
	);

`ifndef SYNTHESIS
	a_busy_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_step || cmd.div_step || cmd.sqrt_step) |-> !samples.ready)
		else $error("sample request taken while the fit is running");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!results.valid || results.ready))
		else $error("result overwrote one not yet taken");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> results.valid)
		else $error("loaded result not offered");

	a_commit_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_commit |-> $past(cmd.mul_step))
		else $error("product committed without a multiply run");
`endif

endmodule

// ----- rtl/llsf_ctrl.sv -----
module llsf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  llsf_pkg::stat_t stat,
	output llsf_pkg::cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_ACC   = 10'b00_0000_0001,
		S_MLOAD = 10'b00_0000_0010,
		S_MRUN  = 10'b00_0000_0100,
		S_MCMT  = 10'b00_0000_1000,
		S_DLOAD = 10'b00_0001_0000,
		S_DRUN  = 10'b00_0010_0000,
		S_DSTO  = 10'b00_0100_0000,
		S_SLOAD = 10'b00_1000_0000,
		S_SQRT  = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	state_t                            state_q;
	logic [llsf_pkg::STEP_W-1:0]       step_q;
	logic [llsf_pkg::ITER_W-1:0]       iter_q;
	logic                              out_valid_q;
	logic                              in_fire;
	llsf_pkg::step_t                   cur;
	llsf_pkg::step_t                   nxt;

	function automatic state_t entry(input llsf_pkg::kind_t k);
		state_t s;
		unique case (k)
			llsf_pkg::K_MUL:  s = S_MLOAD;
			llsf_pkg::K_DIV:  s = S_DLOAD;
			llsf_pkg::K_SQRT: s = S_SLOAD;
			default:          s = S_OUT;
		endcase
		return s;
	endfunction

	assign cur       = llsf_pkg::program_step(step_q);
	assign nxt       = llsf_pkg::program_step(step_q + llsf_pkg::STEP_W'(1));
	assign in_ready  = (state_q == S_ACC);
	assign in_fire   = in_valid & in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.src_a   = cur.src_a;
		cmd.src_b   = cur.src_b;
		cmd.dst     = cur.dst;
		cmd.sub     = cur.sub;
		cmd.div_sel = cur.div_sel;
		unique case (state_q)
			S_ACC:   cmd.acc_en     = in_fire;
			S_MLOAD: cmd.mul_load   = 1'b1;
			S_MRUN:  cmd.mul_step   = 1'b1;
			S_MCMT:  cmd.mul_commit = 1'b1;
			S_DLOAD: cmd.div_load   = 1'b1;
			S_DRUN:  cmd.div_step   = 1'b1;
			S_DSTO:  cmd.div_store  = 1'b1;
			S_SLOAD: cmd.sqrt_load  = 1'b1;
			S_SQRT:  cmd.sqrt_step  = 1'b1;
			S_OUT:   cmd.res_load   = ~out_valid_q | out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			step_q  <= '0;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				S_ACC: begin
					if (in_fire && in_last) begin
						step_q  <= '0;
						state_q <= S_MLOAD;
					end
				end
				S_MLOAD: begin
					iter_q  <= '0;
					state_q <= S_MRUN;
				end
				S_MRUN: begin
					iter_q <= iter_q + llsf_pkg::ITER_W'(1);
					if (iter_q == llsf_pkg::MUL_LAST) state_q <= S_MCMT;
				end
				S_MCMT: begin
					// too few points or no x spread: skip the rest of the fit
					if (step_q == llsf_pkg::CHECK_STEP &&
							(stat.few_points || stat.zero_spread)) begin
						state_q <= S_OUT;
					end else begin
						step_q  <= step_q + llsf_pkg::STEP_W'(1);
						state_q <= entry(nxt.kind);
					end
				end
				S_DLOAD: begin
					iter_q  <= '0;
					state_q <= S_DRUN;
				end
				S_DRUN: begin
					iter_q <= iter_q + llsf_pkg::ITER_W'(1);
					if (iter_q == llsf_pkg::DIV_LAST) state_q <= S_DSTO;
				end
				S_DSTO: begin
					step_q  <= step_q + llsf_pkg::STEP_W'(1);
					state_q <= entry(nxt.kind);
				end
				S_SLOAD: begin
					iter_q  <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					iter_q <= iter_q + llsf_pkg::ITER_W'(1);
					if (iter_q == llsf_pkg::SQRT_LAST) state_q <= S_OUT;
				end
				S_OUT: begin
					if (cmd.res_load) state_q <= S_ACC;
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/llsf_dp.sv -----
module llsf_dp #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  llsf_pkg::cmd_t        cmd,
	output llsf_pkg::stat_t       stat,
	input  logic signed [15:0]    x_value,
	input  logic signed [15:0]    y_value,
	output logic signed [31:0]    slope_out,
	output logic signed [31:0]    intercept_out,
	output logic        [31:0]    slope_error_out,
	output logic        [1:0]     fit_status
);

	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int SXW  = 16 + CW;
	localparam int SXXW = 31 + CW;
	localparam int SXYW = 32 + CW;
	localparam int WW   = llsf_pkg::WW;
	localparam int OPW  = llsf_pkg::OPW;
	localparam int NUMW = llsf_pkg::NUMW;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
	localparam logic [CW-1:0] CNT_MIN = CW'(3);

	// running sums
	logic        [CW-1:0]   cnt_q;
	logic signed [SXW-1:0]  sx_q, sy_q;
	logic signed [SXXW-1:0] sxx_q, syy_q;
	logic signed [SXYW-1:0] sxy_q;
	logic signed [31:0]     pxx, pxy, pyy;

	// centered sums and intermediates
	logic signed [WW-1:0] d_q, nxy_q, nyy_q, p_q, e_q, k_q;

	// shift-add multiplier
	logic        [WW-1:0]  ma_q, mp_q;
	logic        [OPW-1:0] mb_q;
	logic                  mneg_q;
	logic signed [WW-1:0]  a_val, b_val, a_mag, b_mag, prod, cur, wr_val;

	// restoring divider
	logic [NUMW-1:0] dn_q;
	logic [WW-1:0]   dr_q, dden_q;
	logic [WW:0]     rs, rdiff;
	logic            ge;
	logic [NUMW-1:0] num_sel;
	logic [WW-1:0]   nxy_mag, p_mag, e_pos;

	// results of the divisions
	logic [31:0]      slope_q, icpt_q;
	logic             slope_sat_q, icpt_sat_q, vsat_q;
	logic [NUMW-1:0]  t_q;
	logic [OPW-1:0]   v_q;

	// bitwise square root
	logic [OPW-1:0] sv_q, sr_q, sb_q, ssum;

	function automatic logic [32:0] sat_signed(input logic [NUMW-1:0] m, input logic neg);
		logic [NUMW-1:0] lim;
		logic [31:0]     v;
		logic            s;
		lim = neg ? NUMW'(33'h0_8000_0000) : NUMW'(33'h0_7FFF_FFFF);
		s   = (m > lim);
		v   = s ? lim[31:0] : m[31:0];
		return {s, neg ? (32'd0 - v) : v};
	endfunction

	function automatic logic signed [WW-1:0] pick(input llsf_pkg::src_t s,
			input logic [CW-1:0] n, input logic signed [SXW-1:0] sx,
			input logic signed [SXW-1:0] sy, input logic signed [SXXW-1:0] sxx,
			input logic signed [SXYW-1:0] sxy, input logic signed [SXXW-1:0] syy,
			input logic signed [WW-1:0] d, input logic signed [WW-1:0] nxy,
			input logic signed [WW-1:0] nyy);
		logic signed [WW-1:0] r;
		unique case (s)
			llsf_pkg::SRC_N:   r = WW'(n);
			llsf_pkg::SRC_N2:  r = WW'(n) - WW'(2);
			llsf_pkg::SRC_SX:  r = WW'(sx);
			llsf_pkg::SRC_SY:  r = WW'(sy);
			llsf_pkg::SRC_SXX: r = WW'(sxx);
			llsf_pkg::SRC_SXY: r = WW'(sxy);
			llsf_pkg::SRC_SYY: r = WW'(syy);
			llsf_pkg::SRC_D:   r = d;
			llsf_pkg::SRC_NXY: r = nxy;
			llsf_pkg::SRC_NYY: r = nyy;
			default:           r = '0;
		endcase
		return r;
	endfunction

	assign pxx = x_value * x_value;
	assign pxy = x_value * y_value;
	assign pyy = y_value * y_value;

	assign stat.few_points  = (cnt_q < CNT_MIN);
	assign stat.zero_spread = (d_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
			syy_q <= '0;
		end else if (cmd.res_load) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
			syy_q <= '0;
		end else if (cmd.acc_en && cnt_q < CNT_MAX) begin
			cnt_q <= cnt_q + CW'(1);
			sx_q  <= sx_q + SXW'(x_value);
			sy_q  <= sy_q + SXW'(y_value);
			sxx_q <= sxx_q + SXXW'(pxx);
			sxy_q <= sxy_q + SXYW'(pxy);
			syy_q <= syy_q + SXXW'(pyy);
		end
	end

	// multiplier operands as sign and magnitude
	always_comb begin
		a_val = pick(cmd.src_a, cnt_q, sx_q, sy_q, sxx_q, sxy_q, syy_q, d_q, nxy_q, nyy_q);
		b_val = pick(cmd.src_b, cnt_q, sx_q, sy_q, sxx_q, sxy_q, syy_q, d_q, nxy_q, nyy_q);
		a_mag = a_val[WW-1] ? -a_val : a_val;
		b_mag = b_val[WW-1] ? -b_val : b_val;
		prod  = mneg_q ? -$signed(mp_q) : $signed(mp_q);
		unique case (cmd.dst)
			llsf_pkg::DST_D:   cur = d_q;
			llsf_pkg::DST_NXY: cur = nxy_q;
			llsf_pkg::DST_NYY: cur = nyy_q;
			llsf_pkg::DST_P:   cur = p_q;
			llsf_pkg::DST_E:   cur = e_q;
			llsf_pkg::DST_K:   cur = k_q;
			default:           cur = '0;
		endcase
		wr_val = cmd.sub ? cur - prod : prod;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			ma_q   <= {{(WW-OPW){1'b0}}, a_mag[OPW-1:0]};
			mb_q   <= b_mag[OPW-1:0];
			mp_q   <= '0;
			mneg_q <= a_val[WW-1] ^ b_val[WW-1];
		end else if (cmd.mul_step) begin
			if (mb_q[0]) mp_q <= mp_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_commit) begin
			unique case (cmd.dst)
				llsf_pkg::DST_D:   d_q   <= wr_val;
				llsf_pkg::DST_NXY: nxy_q <= wr_val;
				llsf_pkg::DST_NYY: nyy_q <= wr_val;
				llsf_pkg::DST_P:   p_q   <= wr_val;
				llsf_pkg::DST_E:   e_q   <= wr_val;
				llsf_pkg::DST_K:   k_q   <= wr_val;
				default: ;
			endcase
		end
	end

	// divider numerator: magnitudes scaled to the output fraction
	always_comb begin
		nxy_mag = nxy_q[WW-1] ? -nxy_q : nxy_q;
		p_mag   = p_q[WW-1] ? -p_q : p_q;
		e_pos   = e_q[WW-1] ? '0 : e_q;
		unique case (cmd.div_sel)
			llsf_pkg::DV_SLOPE: num_sel = NUMW'(nxy_mag) << 16;
			llsf_pkg::DV_ICPT:  num_sel = NUMW'(p_mag) << 8;
			llsf_pkg::DV_T:     num_sel = NUMW'(e_pos) << 32;
			llsf_pkg::DV_V:     num_sel = t_q;
			default:            num_sel = '0;
		endcase
		rs    = {dr_q, dn_q[NUMW-1]};
		ge    = (rs >= {1'b0, dden_q});
		rdiff = rs - {1'b0, dden_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dn_q   <= num_sel;
			dr_q   <= '0;
			dden_q <= (cmd.div_sel == llsf_pkg::DV_V) ? k_q : d_q;
		end else if (cmd.div_step) begin
			dr_q <= ge ? rdiff[WW-1:0] : rs[WW-1:0];
			dn_q <= {dn_q[NUMW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			unique case (cmd.div_sel)
				llsf_pkg::DV_SLOPE: {slope_sat_q, slope_q} <= sat_signed(dn_q, nxy_q[WW-1]);
				llsf_pkg::DV_ICPT:  {icpt_sat_q, icpt_q}   <= sat_signed(dn_q, p_q[WW-1]);
				llsf_pkg::DV_T:     t_q <= dn_q;
				llsf_pkg::DV_V: begin
					v_q    <= dn_q[OPW-1:0];
					vsat_q <= |dn_q[NUMW-1:OPW];
				end
				default: ;
			endcase
		end
	end

	assign ssum = sr_q + sb_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			sv_q <= v_q;
			sr_q <= '0;
			sb_q <= OPW'(1) << (OPW - 2);
		end else if (cmd.sqrt_step) begin
			if (sv_q >= ssum) begin
				sv_q <= sv_q - ssum;
				sr_q <= (sr_q >> 1) + sb_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sb_q <= sb_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (stat.few_points) begin
				slope_out       <= '0;
				intercept_out   <= '0;
				slope_error_out <= '0;
				fit_status      <= llsf_pkg::ST_FEW;
			end else if (stat.zero_spread) begin
				slope_out       <= '0;
				intercept_out   <= '0;
				slope_error_out <= '0;
				fit_status      <= llsf_pkg::ST_FLAT;
			end else begin
				slope_out       <= slope_q;
				intercept_out   <= icpt_q;
				slope_error_out <= vsat_q ? '1 : sr_q[31:0];
				fit_status      <= (slope_sat_q | icpt_sat_q | vsat_q) ?
					llsf_pkg::ST_SAT : llsf_pkg::ST_OK;
			end
		end
	end

endmodule
